[src/amct_pkg.sv]
// Package for the affine matrix compose/transform block.
// Function codes, sequencer states, fixed-point constants and stream widths.
// No dependencies.
package amct_pkg;

  localparam int WORD_WIDTH_DEF = 32;
  localparam int ACC_W          = 64;  // intermediate products and dividends
  localparam int FRAC_BITS      = 20;  // 1.11.20 linear terms
  localparam int SCALE_SHIFT    = 9;   // 1.6.9 scale factors
  localparam int SHIFT_FRAC     = 16;  // translation fraction dropped on transform
  localparam int CNT_W          = 6;   // bit counter, up to ACC_W steps
  localparam int IN_BITS        = 290;
  localparam int IN_TDATA_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS       = 65;
  localparam int OUT_TDATA_W    = ((OUT_BITS + 7) / 8) * 8;
  localparam int DIVR_W         = 17;  // divisor magnitude, holds 2^15

  typedef enum logic [1:0] {
    FN_IDENTITY  = 2'd0,
    FN_COMPOSE   = 2'd1,
    FN_SCALE     = 2'd2,
    FN_TRANSFORM = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MLOAD,
    ST_MUL,
    ST_DLOAD,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

[src/affine_matrix_compose_transform.sv]
// Top level of the affine matrix compose/transform block.
// Keeps the matrix and runs one shared shift-add multiplier and one
// restoring divider under a small sequencer. Depends on amct_pkg.
//
// Usage
// - Input items arrive on s_tvalid/s_tready/s_tdata, one command each:
//   identity, compose a matrix, scale by two factors, or map a point.
// - Every item yields exactly one result item on m_tvalid/m_tready/m_tdata
//   (status, out_x, out_y).
// - Work per item, from accept to result:
//     identity, or scale with a zero factor: no multiply or divide, straight to done
//     compose: 4 jobs x 2 products, each a load step and a 32-bit shift-add
//     scale: 4 terms, each a load step and a 64-bit restoring divide
//     transform: 2 jobs x 2 products, each a load step and a WORD_WIDTH-bit shift-add
//   The shift-add multiplier retires one multiplier bit per cycle and the
//   divider one quotient bit per cycle.
// - s_tready is high only while the sequencer is idle: one item at a time.
// - The result sits in an output register. A stalled receiver holds that
//   register; the next item can still be accepted and worked on, and its
//   result waits in the done state until the register is free.
// - Reset (rst, synchronous) restores the identity matrix, clears the
//   translations and drops any pending result.
module affine_matrix_compose_transform #(
  parameter int WORD_WIDTH = amct_pkg::WORD_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // func[1:0], in_a, in_b, in_c, in_d, in_e, in_f, scale_x, scale_y,
  // point_x, point_y from the lowest bit up, zero padded
  input  logic [amct_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // status, out_x, out_y from the lowest bit up, zero padded
  output logic [amct_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import amct_pkg::*;

  localparam int W = WORD_WIDTH;
  localparam logic [W-1:0]     ONE_W       = W'(1) << FRAC_BITS;
  localparam logic [CNT_W-1:0] LAST_32     = CNT_W'(31);
  localparam logic [CNT_W-1:0] LAST_W      = CNT_W'(W - 1);
  localparam logic [CNT_W-1:0] LAST_DIV    = CNT_W'(ACC_W - 1);

  // input unpacking
  logic [1:0]         in_func;
  logic signed [31:0] in_a, in_b, in_c, in_d, in_e, in_f, point_x, point_y;
  logic signed [15:0] scale_x, scale_y;

  assign in_func = s_tdata[1:0];
  assign in_a    = s_tdata[33:2];
  assign in_b    = s_tdata[65:34];
  assign in_c    = s_tdata[97:66];
  assign in_d    = s_tdata[129:98];
  assign in_e    = s_tdata[161:130];
  assign in_f    = s_tdata[193:162];
  assign scale_x = s_tdata[209:194];
  assign scale_y = s_tdata[225:210];
  assign point_x = s_tdata[257:226];
  assign point_y = s_tdata[289:258];

  // kept matrix
  logic [W-1:0] term_a, term_b, term_c, term_d, shift_x, shift_y;

  // latched item
  func_t              func_q;
  logic signed [31:0] ia, ib, ic, id;
  logic signed [15:0] sx, sy;
  logic [W-1:0]       tx, ty;

  // sequencer
  state_t           state, state_next;
  logic [1:0]       job;
  logic             ph;
  logic [CNT_W-1:0] cnt, mul_last;

  // multiplier
  logic [ACC_W-1:0] acc, sum, mcand, mplier;
  // divider
  logic [ACC_W-1:0]  dreg;
  logic [DIVR_W-1:0] rem, dmag;
  logic              dneg;

  // staged results
  logic [W-1:0]  res_a, res_b, res_c;
  logic          status_q;
  logic [31:0]   ox, oy;

  logic transform, last_job, is_accept;
  assign transform = (func_q == FN_TRANSFORM);
  assign last_job  = transform ? job[0] : (job == 2'd3);
  assign is_accept = s_tvalid && s_tready;
  assign s_tready  = (state == ST_IDLE);

  // accept-side translation adds and point offsets
  logic [ACC_W-1:0] shx_asr, shy_asr;
  assign shx_asr = ACC_W'($signed(ACC_W'($signed(shift_x))) >>> SHIFT_FRAC);
  assign shy_asr = ACC_W'($signed(ACC_W'($signed(shift_y))) >>> SHIFT_FRAC);

  // operand selection for the multiplier
  logic [W-1:0]     cand_term;
  logic [ACC_W-1:0] mplier_sel;
  always_comb begin
    case ({ph, job[0]})
      2'b00:   cand_term = term_a;
      2'b01:   cand_term = term_b;
      2'b10:   cand_term = term_c;
      default: cand_term = term_d;
    endcase
    if (transform) begin
      mplier_sel = ph ? ACC_W'($signed(ty)) : ACC_W'($signed(tx));
    end else begin
      case ({job[1], ph})
        2'b00:   mplier_sel = ACC_W'(ia);
        2'b01:   mplier_sel = ACC_W'(ib);
        2'b10:   mplier_sel = ACC_W'(ic);
        default: mplier_sel = ACC_W'(id);
      endcase
    end
  end

  // one shift-add step; the top multiplier bit carries negative weight
  logic [ACC_W-1:0] mul_add, acc_step, acc_asr, mul_res;
  assign mul_add  = !mplier[0] ? '0 : ((cnt == mul_last) ? (~mcand + 1'b1) : mcand);
  assign acc_step = acc + mul_add;
  assign acc_asr  = ACC_W'($signed(acc_step) >>> FRAC_BITS);
  assign mul_res  = (transform ? sum : '0) + acc_asr;

  // divider operand selection and one restoring step
  logic [W-1:0]      div_term;
  logic [ACC_W-1:0]  dividend;
  logic signed [15:0] div_s;
  logic [DIVR_W-1:0] div_s17;
  logic [DIVR_W-1:0] trial;
  logic              ge;
  logic [ACC_W-1:0]  quot, quot_s;
  always_comb begin
    case (job)
      2'd0:    div_term = term_a;
      2'd1:    div_term = term_b;
      2'd2:    div_term = term_c;
      default: div_term = term_d;
    endcase
  end
  assign dividend = ACC_W'($signed(div_term)) << SCALE_SHIFT;
  assign div_s    = job[1] ? sy : sx;
  assign div_s17  = DIVR_W'(div_s);
  assign trial    = {rem[DIVR_W-2:0], dreg[ACC_W-1]};
  assign ge       = (trial >= dmag);
  assign quot     = {dreg[ACC_W-2:0], ge};
  assign quot_s   = dneg ? (~quot + 1'b1) : quot;

  logic [W-1:0] step_res;
  assign step_res = (state == ST_DIV) ? quot_s[W-1:0] : mul_res[W-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (is_accept) begin
          unique case (func_t'(in_func))
            FN_IDENTITY:  state_next = ST_DONE;
            FN_COMPOSE:   state_next = ST_MLOAD;
            FN_SCALE:     state_next = (scale_x == '0 || scale_y == '0) ? ST_DONE : ST_DLOAD;
            FN_TRANSFORM: state_next = ST_MLOAD;
            default:      state_next = ST_DONE;
          endcase
        end
      end
      ST_MLOAD: state_next = ST_MUL;
      ST_MUL: begin
        if (cnt == mul_last) begin
          state_next = (ph && last_job) ? ST_DONE : ST_MLOAD;
        end
      end
      ST_DLOAD: state_next = ST_DIV;
      ST_DIV: begin
        if (cnt == LAST_DIV) begin
          state_next = (job == 2'd3) ? ST_DONE : ST_DLOAD;
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control state: kept matrix and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      term_a   <= ONE_W;
      term_b   <= '0;
      term_c   <= '0;
      term_d   <= ONE_W;
      shift_x  <= '0;
      shift_y  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // a new result loads the output register, else a taken one clears it
      if (state == ST_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (is_accept) begin
            if (func_t'(in_func) == FN_IDENTITY) begin
              term_a  <= ONE_W;
              term_b  <= '0;
              term_c  <= '0;
              term_d  <= ONE_W;
              shift_x <= '0;
              shift_y <= '0;
            end else if (func_t'(in_func) == FN_COMPOSE) begin
              shift_x <= shift_x + W'(ACC_W'(in_e));
              shift_y <= shift_y + W'(ACC_W'(in_f));
            end
          end
        end
        ST_MUL: begin
          if (cnt == mul_last && ph && last_job && !transform) begin
            term_a <= res_a;
            term_b <= res_b;
            term_c <= res_c;
            term_d <= step_res;
          end
        end
        ST_DIV: begin
          if (cnt == LAST_DIV && job == 2'd3) begin
            term_a <= res_a;
            term_b <= res_b;
            term_c <= res_c;
            term_d <= step_res;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (is_accept) begin
          func_q   <= func_t'(in_func);
          ia       <= in_a;
          ib       <= in_b;
          ic       <= in_c;
          id       <= in_d;
          sx       <= scale_x;
          sy       <= scale_y;
          tx       <= W'(ACC_W'(point_x) + shx_asr);
          ty       <= W'(ACC_W'(point_y) + shy_asr);
          status_q <= (func_t'(in_func) == FN_SCALE) && (scale_x == '0 || scale_y == '0);
          ox       <= '0;
          oy       <= '0;
          job      <= '0;
          ph       <= 1'b0;
        end
      end
      ST_MLOAD: begin
        mcand    <= ACC_W'($signed(cand_term));
        mplier   <= mplier_sel;
        mul_last <= transform ? LAST_W : LAST_32;
        cnt      <= '0;
        if (!ph) begin
          acc <= '0;
          sum <= '0;
        end else if (transform) begin
          acc <= '0;
        end
      end
      ST_MUL: begin
        acc    <= acc_step;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        cnt    <= cnt + 1'b1;
        if (cnt == mul_last) begin
          if (!ph) begin
            ph <= 1'b1;
            if (transform) begin
              sum <= acc_asr;
            end
          end else begin
            ph  <= 1'b0;
            job <= job + 1'b1;
            if (transform) begin
              if (job[0]) begin
                oy <= 32'(ACC_W'($signed(step_res)));
              end else begin
                ox <= 32'(ACC_W'($signed(step_res)));
              end
            end else begin
              case (job)
                2'd0:    res_a <= step_res;
                2'd1:    res_b <= step_res;
                default: res_c <= step_res;
              endcase
            end
          end
        end
      end
      ST_DLOAD: begin
        dreg <= dividend[ACC_W-1] ? (~dividend + 1'b1) : dividend;
        dmag <= div_s[15] ? (~div_s17 + 1'b1) : div_s17;
        dneg <= dividend[ACC_W-1] ^ div_s[15];
        rem  <= '0;
        cnt  <= '0;
      end
      ST_DIV: begin
        rem  <= ge ? (trial - dmag) : trial;
        dreg <= quot;
        cnt  <= cnt + 1'b1;
        if (cnt == LAST_DIV) begin
          job <= job + 1'b1;
          case (job)
            2'd0:    res_a <= step_res;
            2'd1:    res_b <= step_res;
            default: res_c <= step_res;
          endcase
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= OUT_TDATA_W'({oy, ox, status_q});
        end
      end
      default: ;
    endcase
  end

  // a failed scale reports zero coordinates
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> (m_tdata[64:1] == '0))
    else $error("failure result carries nonzero coordinates");

  // one item at a time: no accept right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    is_accept |=> !s_tready)
    else $error("accepted an item while busy");

  // multiplier bit counter stays within the operand
  a_mul_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> (cnt <= mul_last))
    else $error("multiplier counter overran");

  // a finished result never overwrites a pending one
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata))
    else $error("pending result overwritten");

endmodule
